### hdl/lge_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lge_pkg
// Shared types for the life grid generation engine: payload words, opcodes,
// controller states and the command/status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package lge_pkg;

    typedef enum logic [1:0] {
        OP_TOGGLE = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_STEP   = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [5:0] cell_row;
        logic [5:0] cell_col;
    } in_word_t;

    typedef struct packed {
        logic        cell_alive;
        logic [63:0] row_bits;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_INIT       = 4'd0,
        ST_IDLE       = 4'd1,
        ST_TGL_RD     = 4'd2,
        ST_TGL_WR     = 4'd3,
        ST_CLR        = 4'd4,
        ST_STEP_PRIME = 4'd5,
        ST_STEP_FILL  = 4'd6,
        ST_STEP_ROW   = 4'd7,
        ST_RD_RD      = 4'd8,
        ST_RD_DATA    = 4'd9,
        ST_DONE       = 4'd10
    } state_t;

    typedef enum logic [2:0] {
        RD_NONE = 3'd0,
        RD_ITEM = 3'd1,
        RD_CNT  = 3'd2,
        RD_CNT1 = 3'd3,
        RD_CNT2 = 3'd4
    } rd_src_t;

    typedef enum logic [1:0] {
        RES_ZERO   = 2'd0,
        RES_TOGGLE = 2'd1,
        RES_READ   = 2'd2
    } res_kind_t;

    typedef struct packed {
        logic      load_item;
        logic      cnt_inc;
        logic      wr_zero;
        logic      wr_toggle;
        logic      wr_step;
        logic      win_fill;
        rd_src_t   rd_src;
        logic      res_ld;
        res_kind_t res_kind;
        logic      out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic cnt_last;
        logic out_busy;
    } dp_stat_t;

endpackage

### hdl/lge_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lge_controller
// Sequencer for the engine: clearing pass after reset, opcode dispatch and
// the per-op command sequences that drive the datapath.
// ----------------------------------------------------------------------------
module lge_controller (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  lge_pkg::op_t     s_op,
    input  lge_pkg::dp_stat_t stat,
    output lge_pkg::dp_cmd_t cmd
);
    import lge_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_INIT: begin
                cmd.wr_zero = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (stat.cnt_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    case (s_op)
                        OP_TOGGLE: state_next = ST_TGL_RD;
                        OP_CLEAR:  state_next = ST_CLR;
                        OP_STEP:   state_next = ST_STEP_PRIME;
                        OP_READ:   state_next = ST_RD_RD;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_TGL_RD: begin
                cmd.rd_src = RD_ITEM;
                state_next = ST_TGL_WR;
            end
            ST_TGL_WR: begin
                cmd.wr_toggle = 1'b1;
                cmd.res_ld    = 1'b1;
                cmd.res_kind  = RES_TOGGLE;
                state_next    = ST_DONE;
            end
            ST_CLR: begin
                cmd.wr_zero = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (stat.cnt_last) begin
                    cmd.res_ld   = 1'b1;
                    cmd.res_kind = RES_ZERO;
                    state_next   = ST_DONE;
                end
            end
            ST_STEP_PRIME: begin
                cmd.rd_src = RD_CNT;
                state_next = ST_STEP_FILL;
            end
            ST_STEP_FILL: begin
                cmd.win_fill = 1'b1;
                cmd.rd_src   = RD_CNT1;
                state_next   = ST_STEP_ROW;
            end
            ST_STEP_ROW: begin
                cmd.wr_step = 1'b1;
                cmd.rd_src  = RD_CNT2;
                cmd.cnt_inc = 1'b1;
                if (stat.cnt_last) begin
                    cmd.res_ld   = 1'b1;
                    cmd.res_kind = RES_ZERO;
                    state_next   = ST_DONE;
                end
            end
            ST_RD_RD: begin
                cmd.rd_src = RD_ITEM;
                state_next = ST_RD_DATA;
            end
            ST_RD_DATA: begin
                cmd.res_ld   = 1'b1;
                cmd.res_kind = RES_READ;
                state_next   = ST_DONE;
            end
            ST_DONE: begin
                if (!stat.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### hdl/lge_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lge_datapath
// Grid memory, row counter, three-row step window, B3/S23 row update,
// result register and output register.
// ----------------------------------------------------------------------------
module lge_datapath #(
    parameter int ROWS = 64,
    parameter int COLS = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  lge_pkg::in_word_t s_data,
    input  lge_pkg::dp_cmd_t  cmd,
    output lge_pkg::dp_stat_t stat,
    output logic              m_valid,
    input  logic              m_ready,
    output lge_pkg::out_word_t m_data
);
    import lge_pkg::*;

    localparam int AW = $clog2(ROWS);
    localparam int EW = (AW + 1 > 6) ? AW + 1 : 6;

    function automatic logic [COLS-1:0] next_row(
        input logic [COLS-1:0] above,
        input logic [COLS-1:0] here,
        input logic [COLS-1:0] below
    );
        logic [COLS+1:0] a;
        logic [COLS+1:0] h;
        logic [COLS+1:0] b;
        logic [3:0]      n;
        logic [COLS-1:0] res;
        a   = {1'b0, above, 1'b0};
        h   = {1'b0, here, 1'b0};
        b   = {1'b0, below, 1'b0};
        res = '0;
        for (int c = 0; c < COLS; c++) begin
            n = 4'(a[c]) + 4'(a[c+1]) + 4'(a[c+2]) + 4'(h[c]) + 4'(h[c+2])
              + 4'(b[c]) + 4'(b[c+1]) + 4'(b[c+2]);
            res[c] = h[c+1] ? (n == 4'd2 || n == 4'd3) : (n == 4'd3);
        end
        return res;
    endfunction

    logic [COLS-1:0] grid_mem [ROWS];
    logic [COLS-1:0] rd_data_reg;

    op_t             item_op_reg;
    logic [5:0]      item_row_reg;
    logic [5:0]      item_col_reg;
    logic [AW-1:0]   cnt_reg;
    logic [COLS-1:0] prev_reg;
    logic [COLS-1:0] cur_reg;
    logic            res_alive_reg;
    logic [63:0]     res_bits_reg;
    logic            out_valid_reg;
    out_word_t       out_data_reg;

    logic            row_ok;
    logic            col_ok;
    logic [COLS-1:0] col_onehot;
    logic [COLS-1:0] tgl_word;
    logic [COLS-1:0] below;
    logic [COLS-1:0] step_word;
    logic [EW-1:0]   rd_addr_ext;
    logic            rd_en;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [COLS-1:0] wr_data;

    assign row_ok     = 32'(item_row_reg) < ROWS;
    assign col_ok     = 32'(item_col_reg) < COLS;
    assign col_onehot = col_ok ? (COLS'(1) << item_col_reg) : '0;
    assign tgl_word   = rd_data_reg ^ col_onehot;
    assign below      = stat.cnt_last ? '0 : rd_data_reg;
    assign step_word  = next_row(prev_reg, cur_reg, below);

    assign stat.cnt_last = 32'(cnt_reg) == ROWS - 1;
    assign stat.out_busy = out_valid_reg && !m_ready;

    always_comb begin
        case (cmd.rd_src)
            RD_ITEM: rd_addr_ext = EW'(item_row_reg);
            RD_CNT:  rd_addr_ext = EW'(cnt_reg);
            RD_CNT1: rd_addr_ext = EW'(cnt_reg) + EW'(1);
            RD_CNT2: rd_addr_ext = EW'(cnt_reg) + EW'(2);
            default: rd_addr_ext = '0;
        endcase
        rd_en = (cmd.rd_src != RD_NONE) && (32'(rd_addr_ext) < ROWS);
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = cnt_reg;
        wr_data = '0;
        if (cmd.wr_zero) begin
            wr_en = 1'b1;
        end else if (cmd.wr_step) begin
            wr_en   = 1'b1;
            wr_data = step_word;
        end else if (cmd.wr_toggle) begin
            wr_en   = row_ok && col_ok;
            wr_addr = AW'(item_row_reg);
            wr_data = tgl_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            grid_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= grid_mem[AW'(rd_addr_ext)];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.load_item) begin
            cnt_reg <= '0;
        end else if (cmd.cnt_inc) begin
            cnt_reg <= stat.cnt_last ? '0 : cnt_reg + AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_op_reg  <= s_data.op;
            item_row_reg <= s_data.cell_row;
            item_col_reg <= s_data.cell_col;
        end
        if (cmd.win_fill) begin
            prev_reg <= '0;
            cur_reg  <= rd_data_reg;
        end else if (cmd.wr_step) begin
            prev_reg <= cur_reg;
            cur_reg  <= below;
        end
        if (cmd.res_ld) begin
            case (cmd.res_kind)
                RES_TOGGLE: begin
                    res_alive_reg <= |(tgl_word & col_onehot) && row_ok
                                     && item_op_reg == OP_TOGGLE;
                    res_bits_reg  <= '0;
                end
                RES_READ: begin
                    res_alive_reg <= 1'b0;
                    res_bits_reg  <= row_ok ? 64'(rd_data_reg) : '0;
                end
                default: begin
                    res_alive_reg <= 1'b0;
                    res_bits_reg  <= '0;
                end
            endcase
        end
        if (cmd.out_load) begin
            out_data_reg.cell_alive <= res_alive_reg;
            out_data_reg.row_bits   <= res_bits_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

### hdl/life_grid_generation_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_grid_generation_engine
// Game of Life (B3/S23) engine on a ROWS by COLS grid; cells off the grid
// count as dead.
//
// Input channel s_valid/s_ready/s_data carries one command word: toggle a
// cell, clear the grid, step one generation, or read one row. Every command
// word yields exactly one result word on m_valid/m_ready/m_data.
// Toggle and read fetch the addressed row, and toggle writes it back with the
// cell flipped; clear writes zero to every row and step sweeps every row
// before the result is loaded. The result then passes to the output register,
// which raises m_valid; s_ready rises with m_valid. One command is worked at
// a time; the step time is set by the sweep of the single-read-port grid
// memory, one row per cycle through a three-row window.
// After reset the grid memory is cleared one row per cycle, so s_ready stays
// low during that clearing pass. The result sits in an output register: while
// the receiver stalls, the next command is accepted and worked, and it waits
// for the register to drain before its own result is loaded.
// ----------------------------------------------------------------------------
module life_grid_generation_engine #(
    parameter int ROWS = 64,
    parameter int COLS = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  lge_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output lge_pkg::out_word_t m_data
);
    import lge_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    lge_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_data.op),
        .stat    (stat),
        .cmd     (cmd)
    );

    lge_datapath #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("accepted a word while a command was in flight");

    a_init_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("ready during the post-reset clearing pass");

    a_alive_excl_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.cell_alive |-> m_data.row_bits == 64'd0)
        else $error("toggle result carries row bits");

    a_bits_in_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.row_bits >> COLS) == 64'd0)
        else $error("row bits beyond the grid width");

endmodule
